// ===== rtl/hmtg_pkg.sv =====
package hmtg_pkg;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int HEIGHT_W   = 8;
  localparam int COORD_W    = 12;
  localparam int NORM_W     = 9;
  localparam int NORMY_W    = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

  localparam logic [CFG_W-1:0] GRID_DIM_RESET = 11'd256;

  // job queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  // vertex slots within one job: six cell vertices, then six bottom-quad vertices
  localparam logic [3:0] VTX_CELL_FIRST   = 4'd0;
  localparam logic [3:0] VTX_CELL_LAST    = 4'd5;
  localparam logic [3:0] VTX_BOTTOM_FIRST = 4'd6;
  localparam logic [3:0] VTX_BOTTOM_LAST  = 4'd11;

  localparam logic signed [NORMY_W-1:0] NORMY_UP   = 2'sb01;
  localparam logic signed [NORMY_W-1:0] NORMY_DOWN = 2'sb11;

  typedef struct packed {
    logic [HEIGHT_W-1:0]       h0;
    logic [HEIGHT_W-1:0]       h1;
    logic [HEIGHT_W-1:0]       h2;
    logic [HEIGHT_W-1:0]       h3;
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] za;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] hz;
    logic                      is_cell;
    logic                      bottom;
  } job_t;

  typedef struct packed {
    logic             empty;
    logic [LVL_W-1:0] level;
  } fifo_stat_t;

endpackage

// ===== rtl/hmtg_front.sv =====
module hmtg_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic [hmtg_pkg::HEIGHT_W-1:0]  s_height_i,
  input  logic [hmtg_pkg::CFG_W-1:0]     cols_i,
  input  logic [hmtg_pkg::CFG_W-1:0]     rows_i,
  input  hmtg_pkg::fifo_stat_t           fifo_stat_i,
  output logic                           push_o,
  output hmtg_pkg::job_t                 job_o
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int WW  = CW + 1;
  localparam int HW  = RW + 1;
  localparam int EW0 = (WW > HW) ? WW : HW;
  localparam int EW  = (EW0 > hmtg_pkg::CFG_W) ? EW0 : hmtg_pkg::CFG_W;
  localparam int CRD = hmtg_pkg::COORD_W;

  logic [EW-1:0] cols_ext, rows_ext, w_ext, h_ext;
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          accept, last_row, last_col;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [hmtg_pkg::HEIGHT_W-1:0] store_q [MAX_ROWS];
  logic [hmtg_pkg::HEIGHT_W-1:0] old_q, prev_new_q, prev_old_q;

  logic                          a_valid_q;
  logic [hmtg_pkg::HEIGHT_W-1:0] a_s_q, a_h2_q;
  logic [CRD-1:0]                a_xa_q, a_za_q, a_wx_q, a_hz_q;
  logic                          a_cell_q, a_bot_q;
  logic [hmtg_pkg::LVL_W:0]      inflight;

  // clamp the grid dimensions to [2, MAX]
  always_comb begin
    cols_ext = EW'(cols_i);
    rows_ext = EW'(rows_i);
    if (cols_ext < EW'(2)) begin
      w_ext = EW'(2);
    end else if (cols_ext > EW'(MAX_COLUMNS)) begin
      w_ext = EW'(MAX_COLUMNS);
    end else begin
      w_ext = cols_ext;
    end
    if (rows_ext < EW'(2)) begin
      h_ext = EW'(2);
    end else if (rows_ext > EW'(MAX_ROWS)) begin
      h_ext = EW'(MAX_ROWS);
    end else begin
      h_ext = rows_ext;
    end
  end

  assign w = w_ext[WW-1:0];
  assign h = h_ext[HW-1:0];

  assign last_row = HW'(row_q) >= (h - HW'(1));
  assign last_col = WW'(col_q) >= (w - WW'(1));

  // hold off while the queue could not take what is in flight
  assign inflight  = {1'b0, fifo_stat_i.level} + (hmtg_pkg::LVL_W+1)'(a_valid_q);
  assign s_ready_o = inflight < (hmtg_pkg::LVL_W+1)'(hmtg_pkg::FIFO_DEPTH);
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (last_row) begin
      row_d = '0;
      col_d = last_col ? '0 : col_q + CW'(1);
    end else begin
      row_d = row_q + RW'(1);
    end
  end

  // column store: read the previous column's height, then overwrite it
  always_ff @(posedge clk_i) begin
    if (accept) begin
      old_q          <= store_q[row_q];
      store_q[row_q] <= s_height_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      prev_new_q <= '0;
      prev_old_q <= '0;
      a_valid_q  <= 1'b0;
    end else begin
      a_valid_q <= accept;
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        prev_new_q <= s_height_i;
      end
      if (a_valid_q) begin
        prev_old_q <= old_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_s_q    <= s_height_i;
      a_h2_q   <= prev_new_q;
      a_xa_q   <= CRD'({col_q - CW'(1), 1'b0}) - CRD'(w);
      a_za_q   <= CRD'({row_q - RW'(1), 1'b0}) - CRD'(h);
      a_wx_q   <= CRD'(w);
      a_hz_q   <= CRD'(h);
      a_cell_q <= (col_q != '0) && (row_q != '0);
      a_bot_q  <= last_row && last_col;
    end
  end

  assign push_o = a_valid_q && (a_cell_q || a_bot_q);

  always_comb begin
    job_o.h0      = prev_old_q;
    job_o.h1      = old_q;
    job_o.h2      = a_h2_q;
    job_o.h3      = a_s_q;
    job_o.xa      = a_xa_q;
    job_o.za      = a_za_q;
    job_o.wx      = a_wx_q;
    job_o.hz      = a_hz_q;
    job_o.is_cell = a_cell_q;
    job_o.bottom  = a_bot_q;
  end

endmodule

// ===== rtl/hmtg_fifo.sv =====
module hmtg_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  hmtg_pkg::job_t       job_i,
  input  logic                 pop_i,
  output hmtg_pkg::job_t       job_o,
  output hmtg_pkg::fifo_stat_t stat_o
);

  hmtg_pkg::job_t                  mem_q [hmtg_pkg::FIFO_DEPTH];
  logic [hmtg_pkg::PTR_W-1:0]      wr_q, rd_q;
  logic [hmtg_pkg::LVL_W-1:0]      level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + hmtg_pkg::PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + hmtg_pkg::PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + hmtg_pkg::LVL_W'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - hmtg_pkg::LVL_W'(1);
      end
    end
  end

  assign job_o        = mem_q[rd_q];
  assign stat_o.level = level_q;
  assign stat_o.empty = (level_q == '0);

endmodule

// ===== rtl/hmtg_back.sv =====
module hmtg_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hmtg_pkg::job_t                    job_i,
  input  hmtg_pkg::fifo_stat_t              fifo_stat_i,
  output logic                              pop_o,
  output logic                              m_valid_o,
  input  logic                              m_ready_i,
  output logic [hmtg_pkg::OUT_DATA_W-1:0]   m_data_o,
  output logic                              m_last_o
);

  hmtg_pkg::job_t job_q;
  logic           job_valid_q;
  logic [3:0]     idx_q, end_idx, first_idx;
  logic           out_adv, emit, job_done;

  logic        m_valid_q, m_last_q;
  logic [hmtg_pkg::OUT_DATA_W-1:0] m_data_q;

  logic signed [hmtg_pkg::COORD_W-1:0] vx, vz, xb, zb;
  logic [hmtg_pkg::HEIGHT_W-1:0]       vy;
  logic signed [hmtg_pkg::NORM_W-1:0]  nx, nz, ax, az, bx, bz;
  logic signed [hmtg_pkg::NORMY_W-1:0] ny;

  assign out_adv   = !m_valid_q || m_ready_i;
  assign emit      = job_valid_q && out_adv;
  assign end_idx   = job_q.bottom ? hmtg_pkg::VTX_BOTTOM_LAST : hmtg_pkg::VTX_CELL_LAST;
  assign first_idx = job_i.is_cell ? hmtg_pkg::VTX_CELL_FIRST : hmtg_pkg::VTX_BOTTOM_FIRST;
  assign job_done  = emit && (idx_q == end_idx);
  assign pop_o     = !fifo_stat_i.empty && (!job_valid_q || job_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      job_valid_q <= 1'b1;
      idx_q       <= first_idx;
    end else if (job_done) begin
      job_valid_q <= 1'b0;
    end else if (emit) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  assign xb = job_q.xa + hmtg_pkg::COORD_W'(2);
  assign zb = job_q.za + hmtg_pkg::COORD_W'(2);
  assign ax = $signed({1'b0, job_q.h0}) - $signed({1'b0, job_q.h2});
  assign az = $signed({1'b0, job_q.h0}) - $signed({1'b0, job_q.h1});
  assign bx = $signed({1'b0, job_q.h1}) - $signed({1'b0, job_q.h3});
  assign bz = $signed({1'b0, job_q.h2}) - $signed({1'b0, job_q.h3});

  always_comb begin
    vx = job_q.xa;
    vy = job_q.h0;
    vz = job_q.za;
    nx = ax;
    ny = hmtg_pkg::NORMY_UP;
    nz = az;
    unique case (idx_q)
      4'd0: begin
        vx = job_q.xa; vy = job_q.h0; vz = job_q.za;
      end
      4'd1: begin
        vx = job_q.xa; vy = job_q.h1; vz = zb;
      end
      4'd2: begin
        vx = xb; vy = job_q.h2; vz = job_q.za;
      end
      4'd3: begin
        vx = xb; vy = job_q.h2; vz = job_q.za; nx = bx; nz = bz;
      end
      4'd4: begin
        vx = job_q.xa; vy = job_q.h1; vz = zb; nx = bx; nz = bz;
      end
      4'd5: begin
        vx = xb; vy = job_q.h3; vz = zb; nx = bx; nz = bz;
      end
      4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11: begin
        vy = '0;
        nx = '0;
        ny = hmtg_pkg::NORMY_DOWN;
        nz = '0;
        // bottom quad corners: (-w,-h) (w,-h) (-w,h) (w,-h) (w,h) (-w,h)
        vx = (idx_q == 4'd7 || idx_q == 4'd9 || idx_q == 4'd10) ? job_q.wx : -job_q.wx;
        vz = (idx_q == 4'd8 || idx_q == 4'd10 || idx_q == 4'd11) ? job_q.hz : -job_q.hz;
      end
      default: begin
        vy = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_adv) begin
      m_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      m_data_q <= {4'd0, nz, ny, nx, vz, vy, vx};
      m_last_q <= job_done;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

endmodule

// ===== rtl/heightmap_triangle_mesh_generator.sv =====
// Heightmap mesh generator. Height samples enter column by column (row index inner) and
// leave as triangle vertices, one vertex per cycle on the master side while the
// output is not stalled: a sample that completes a grid cell gives six vertices, the
// final sample of the grid twelve (cell plus bottom quad), and a sample in the first row
// or first column none. The output port sets the rate; a four-entry job queue sits
// between the sample front end (column store read, counters) and the vertex sequencer,
// so input keeps flowing while vertices wait on m_axis_tready, until the queue fills.
// The column store needs no clearing after reset. Write grid_columns / grid_rows only
// while the block is idle.
module heightmap_triangle_mesh_generator #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] height_sample
  input  logic [hmtg_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] pos_x2, [19:12] pos_y, [31:20] pos_z2, [40:32] norm_x,
  // [42:41] norm_y, [51:43] norm_z, [55:52] zero
  output logic [hmtg_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [hmtg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hmtg_pkg::CFG_W-1:0]        cfg_data_i
);

  logic [hmtg_pkg::CFG_W-1:0] cols_q, rows_q;
  logic                       push, pop;
  hmtg_pkg::job_t             job_in, job_head;
  hmtg_pkg::fifo_stat_t       fifo_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= hmtg_pkg::GRID_DIM_RESET;
      rows_q <= hmtg_pkg::GRID_DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hmtg_pkg::REG_GRID_COLUMNS: cols_q <= cfg_data_i;
        hmtg_pkg::REG_GRID_ROWS:    rows_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hmtg_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_height_i  (s_axis_tdata),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .job_o       (job_in)
  );

  hmtg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_head),
    .stat_o (fifo_stat)
  );

  hmtg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

// ===== rtl/hmtg_checker.sv =====
module hmtg_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hmtg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  // no vertex offered while in reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("vertex valid during reset");

  // hold a stalled vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled vertex changed");

  // normal y is either up or down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[42:41] == hmtg_pkg::NORMY_UP || m_axis_tdata[42:41] == hmtg_pkg::NORMY_DOWN)
    else $error("bad normal y");

  // bottom-quad vertices sit at height zero with normal (0,-1,0)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[42:41] == hmtg_pkg::NORMY_DOWN |->
      m_axis_tdata[19:12] == '0 && m_axis_tdata[40:32] == '0 && m_axis_tdata[51:43] == '0)
    else $error("bottom vertex not flat");

  // a surface vertex right after a bottom vertex only follows the end of the quad
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[42:41] == hmtg_pkg::NORMY_DOWN
      && !m_axis_tlast |=>
      !(m_axis_tvalid && m_axis_tdata[42:41] == hmtg_pkg::NORMY_UP))
    else $error("bottom quad cut short");

endmodule

bind heightmap_triangle_mesh_generator hmtg_checker u_hmtg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
